### src/triangle_zbuffer_rasterizer_assert.svh
// Assertion macros used by the triangle rasterizer core.
`ifndef TRIANGLE_ZBUFFER_RASTERIZER_ASSERT_SVH
`define TRIANGLE_ZBUFFER_RASTERIZER_ASSERT_SVH
`ifndef SYNTH
`define TZR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tzr assertion failed");
`define TZR_ASSERT_STEP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("tzr step assertion failed");
`else
`define TZR_ASSERT(lbl, clk, rst, prop)
`define TZR_ASSERT_STEP(lbl, clk, rst, pre, post)
`endif
`endif

### src/tzr_pkg.sv
// Types and constants of the triangle rasterizer.
package tzr_pkg;

  localparam int COORD_W      = 12;
  localparam int EDGE_W       = 27;
  localparam int ACC_W        = 44;
  localparam int QUOT_W       = 16;
  localparam int DEPTH_W      = 16;
  localparam int COLOR_W      = 24;
  localparam int COUNT_W      = 15;
  localparam int STORE_AW_MAX = 20;

  localparam logic [DEPTH_W-1:0] DEPTH_FAR         = 16'hFFFF;
  localparam logic [COLOR_W-1:0] CLEAR_COLOR_RESET = 24'h19191E;
  localparam logic [7:0]         VIEW_RESET        = 8'd128;
  localparam logic [COUNT_W-1:0] COUNT_MAX         = 15'h7FFF;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_VIEW_WIDTH  = 2'd0,
    REG_VIEW_HEIGHT = 2'd1,
    REG_CLEAR_COLOR = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_READ_WAIT,
    ST_AREA,
    ST_SETUP,
    ST_EDGE,
    ST_TEST,
    ST_MAC,
    ST_DIV,
    ST_WRITE,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef struct packed {
    opcode_t     opcode;
    coord_t      x0;
    coord_t      y0;
    coord_t      x1;
    coord_t      y1;
    coord_t      x2;
    coord_t      y2;
    logic [39:0] vert0_depth_color;
    logic [39:0] vert1_depth_color;
    logic [39:0] vert2_depth_color;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] pixel_color;
    logic [DEPTH_W-1:0] pixel_depth;
    logic [COUNT_W-1:0] pixels_written;
  } result_t;

  typedef struct packed {
    logic                    we;
    logic [STORE_AW_MAX-1:0] waddr;
    logic [DEPTH_W-1:0]      wdepth;
    logic [COLOR_W-1:0]      wcolor;
    logic                    re;
    logic [STORE_AW_MAX-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    coord_t             last_x;
    coord_t             last_y;
    logic [COLOR_W-1:0] clear_color;
  } view_cfg_t;

  function automatic coord_t min3c(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3c(coord_t a, coord_t b, coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

### src/tzr_store.sv
// Depth and color frame stores with one write and one registered read port.
module tzr_store
  import tzr_pkg::*;
#(
  parameter int DEPTH = 16384
) (
  input  logic               clk,
  input  mem_req_t           req,
  output logic [DEPTH_W-1:0] rdepth,
  output logic [COLOR_W-1:0] rcolor
);

  localparam int AW = $clog2(DEPTH);

  logic [DEPTH_W-1:0] depth_mem [DEPTH];
  logic [COLOR_W-1:0] color_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      depth_mem[req.waddr[AW-1:0]] <= req.wdepth;
      color_mem[req.waddr[AW-1:0]] <= req.wcolor;
    end
    if (req.re) begin
      rdepth <= depth_mem[req.raddr[AW-1:0]];
      rcolor <= color_mem[req.raddr[AW-1:0]];
    end
  end

endmodule

### src/tzr_div.sv
// Restoring divider, one quotient bit per cycle, for quotients known to fit 16 bits.
module tzr_div
  import tzr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  num,
  input  logic [EDGE_W-1:0] den,
  output logic              busy,
  output logic              done,
  output logic [QUOT_W-1:0] quot
);

  localparam int SH_W  = EDGE_W + QUOT_W - 1;
  localparam int CNT_W = $clog2(QUOT_W);

  logic [ACC_W-1:0] rem;
  logic [SH_W-1:0]  dsh;
  logic [CNT_W-1:0] cnt;
  logic             ge;

  assign ge = rem >= ACC_W'(dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(QUOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= num;
      dsh  <= SH_W'(den) << (QUOT_W - 1);
      quot <= '0;
    end else if (busy) begin
      if (ge) begin
        rem <= rem - ACC_W'(dsh);
      end
      quot <= {quot[QUOT_W-2:0], ge};
      dsh  <= dsh >> 1;
    end
  end

endmodule

### src/tzr_core.sv
// Sequencer and datapath: clear sweep, pixel read, triangle scan with depth test.
module tzr_core
  import tzr_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  view_cfg_t          cfg,
  input  logic               start,
  input  item_t              item,
  output logic               idle,
  output logic               res_push,
  input  logic               res_free,
  output result_t            res,
  output mem_req_t           mem_req,
  input  logic [DEPTH_W-1:0] mem_rdepth,
  input  logic [COLOR_W-1:0] mem_rcolor,
  output logic               div_start,
  output logic [ACC_W-1:0]   div_num,
  output logic [EDGE_W-1:0]  div_den,
  input  logic               div_busy,
  input  logic               div_done,
  input  logic [QUOT_W-1:0]  div_quot
);

`include "triangle_zbuffer_rasterizer_assert.svh"

  localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW          = $clog2(STORE_DEPTH);

  state_t state, state_next;

  logic [AW-1:0]      sweep;
  logic               sweep_reply;
  logic [COLOR_W-1:0] clr;

  item_t                   it;
  logic [1:0]              k, s, ch;
  logic signed [ACC_W-1:0] prod, tmp, acc;
  logic signed [EDGE_W-1:0] area, a_abs;
  logic                    area_neg;
  logic signed [EDGE_W-1:0] w [3];
  coord_t                  px, py, lo_x, hi_x, hi_y;
  logic [DEPTH_W-1:0]      z;
  logic [COLOR_W-1:0]      rgb;
  logic [COUNT_W-1:0]      count;
  logic [COLOR_W-1:0]      out_color;
  logic [DEPTH_W-1:0]      out_depth;

  coord_t      vx [3];
  coord_t      vy [3];
  logic [39:0] vdc [3];
  logic [1:0]  ksel, bi, ci, widx;
  coord_t      ppx, ppy;
  logic signed [12:0] d_cb_x, d_cb_y, d_px, d_py;
  logic signed [EDGE_W-1:0] mul_a, edge_val;
  logic signed [16:0]       mul_b;
  logic [15:0]              val;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [STORE_AW_MAX-1:0]  pix_addr, rd_addr;
  logic                     in_view, in_tri, empty;
  coord_t mn_x, mx_x, mn_y, mx_y, lo_x_c, hi_x_c, lo_y_c, hi_y_c;

  function automatic logic signed [12:0] sx13(coord_t c);
    return {c[COORD_W-1], c};
  endfunction

  assign vx[0]  = it.x0;
  assign vy[0]  = it.y0;
  assign vx[1]  = it.x1;
  assign vy[1]  = it.y1;
  assign vx[2]  = it.x2;
  assign vy[2]  = it.y2;
  assign vdc[0] = it.vert0_depth_color;
  assign vdc[1] = it.vert1_depth_color;
  assign vdc[2] = it.vert2_depth_color;

  always_comb begin
    ksel = (state == ST_AREA) ? 2'd2 : k;
    case (ksel)
      2'd0: begin
        bi = 2'd1;
        ci = 2'd2;
      end
      2'd1: begin
        bi = 2'd2;
        ci = 2'd0;
      end
      default: begin
        bi = 2'd0;
        ci = 2'd1;
      end
    endcase
    ppx    = (state == ST_AREA) ? vx[2] : px;
    ppy    = (state == ST_AREA) ? vy[2] : py;
    d_cb_x = sx13(vx[ci]) - sx13(vx[bi]);
    d_cb_y = sx13(vy[ci]) - sx13(vy[bi]);
    d_px   = sx13(ppx) - sx13(vx[bi]);
    d_py   = sx13(ppy) - sx13(vy[bi]);

    widx = (s == 2'd3) ? 2'd0 : s;
    case (ch)
      2'd0:    val = vdc[widx][39:24];
      2'd1:    val = {8'd0, vdc[widx][23:16]};
      2'd2:    val = {8'd0, vdc[widx][15:8]};
      default: val = {8'd0, vdc[widx][7:0]};
    endcase

    if (state == ST_MAC) begin
      mul_a = w[widx];
      mul_b = signed'({1'b0, val});
    end else if (s == 2'd0) begin
      mul_a = EDGE_W'(d_cb_x);
      mul_b = 17'(d_py);
    end else begin
      mul_a = EDGE_W'(d_cb_y);
      mul_b = 17'(d_px);
    end
  end

  assign edge_val = EDGE_W'(tmp - prod);
  assign acc_sum  = acc + prod;
  assign div_num  = unsigned'(acc_sum);
  assign div_den  = unsigned'(a_abs);

  assign pix_addr = STORE_AW_MAX'(int'(py) * MAX_WIDTH + int'(px));
  assign rd_addr  = STORE_AW_MAX'(int'(it.y0) * MAX_WIDTH + int'(it.x0));
  assign in_view  = !it.x0[COORD_W-1] && !it.y0[COORD_W-1] &&
                    (it.x0 <= cfg.last_x) && (it.y0 <= cfg.last_y);
  assign in_tri   = !w[0][EDGE_W-1] && !w[1][EDGE_W-1] && !w[2][EDGE_W-1];

  always_comb begin
    mn_x   = min3c(vx[0], vx[1], vx[2]);
    mx_x   = max3c(vx[0], vx[1], vx[2]);
    mn_y   = min3c(vy[0], vy[1], vy[2]);
    mx_y   = max3c(vy[0], vy[1], vy[2]);
    lo_x_c = mn_x[COORD_W-1] ? '0 : mn_x;
    lo_y_c = mn_y[COORD_W-1] ? '0 : mn_y;
    hi_x_c = (mx_x > cfg.last_x) ? cfg.last_x : mx_x;
    hi_y_c = (mx_y > cfg.last_y) ? cfg.last_y : mx_y;
    empty  = (lo_x_c > hi_x_c) || (lo_y_c > hi_y_c);
  end

  assign res = '{pixel_color: out_color, pixel_depth: out_depth, pixels_written: count};

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      sweep       <= '0;
      sweep_reply <= 1'b0;
      clr         <= CLEAR_COLOR_RESET;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        sweep <= (sweep == AW'(STORE_DEPTH - 1)) ? '0 : sweep + 1'b1;
      end
      if (state == ST_IDLE && start && item.opcode == OP_CLEAR) begin
        clr         <= cfg.clear_color;
        sweep_reply <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    idle       = 1'b0;
    res_push   = 1'b0;
    div_start  = 1'b0;
    mem_req    = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = STORE_AW_MAX'(sweep);
        mem_req.wdepth = DEPTH_FAR;
        mem_req.wcolor = clr;
        if (sweep == AW'(STORE_DEPTH - 1)) begin
          state_next = sweep_reply ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          unique case (item.opcode)
            OP_CLEAR: state_next = ST_CLEAR;
            OP_DRAW:  state_next = ST_AREA;
            OP_READ:  state_next = ST_READ;
            default:  state_next = ST_DONE;
          endcase
        end
      end
      ST_READ: begin
        if (in_view) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = rd_addr;
          state_next    = ST_READ_WAIT;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_READ_WAIT: state_next = ST_DONE;
      ST_AREA: begin
        if (s == 2'd2) begin
          state_next = (edge_val == '0) ? ST_DONE : ST_SETUP;
        end
      end
      ST_SETUP: state_next = empty ? ST_DONE : ST_EDGE;
      ST_EDGE: begin
        if (s == 2'd2 && k == 2'd2) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (in_tri) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = pix_addr;
          state_next    = ST_MAC;
        end else begin
          state_next = ST_NEXT;
        end
      end
      ST_MAC: begin
        if (s == 2'd3) begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (ch == 2'd0) begin
            state_next = (div_quot < mem_rdepth) ? ST_MAC : ST_NEXT;
          end else if (ch == 2'd3) begin
            state_next = ST_WRITE;
          end else begin
            state_next = ST_MAC;
          end
        end
      end
      ST_WRITE: begin
        mem_req.we     = 1'b1;
        mem_req.waddr  = pix_addr;
        mem_req.wdepth = z;
        mem_req.wcolor = rgb;
        state_next     = ST_NEXT;
      end
      ST_NEXT: state_next = (px == hi_x && py == hi_y) ? ST_DONE : ST_EDGE;
      ST_DONE: begin
        res_push = res_free;
        if (res_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= ACC_W'(mul_a) * ACC_W'(mul_b);
    case (state)
      ST_IDLE: begin
        if (start) begin
          it        <= item;
          k         <= '0;
          s         <= '0;
          count     <= '0;
          out_color <= '0;
          out_depth <= '0;
        end
      end
      ST_READ_WAIT: begin
        out_color <= mem_rcolor;
        out_depth <= mem_rdepth;
      end
      ST_AREA: begin
        if (s == 2'd1) begin
          tmp <= prod;
        end
        if (s == 2'd2) begin
          area <= edge_val;
          s    <= '0;
        end else begin
          s <= s + 1'b1;
        end
      end
      ST_SETUP: begin
        area_neg <= area[EDGE_W-1];
        a_abs    <= area[EDGE_W-1] ? -area : area;
        px       <= lo_x_c;
        py       <= lo_y_c;
        lo_x     <= lo_x_c;
        hi_x     <= hi_x_c;
        hi_y     <= hi_y_c;
        k        <= '0;
        s        <= '0;
      end
      ST_EDGE: begin
        if (s == 2'd1) begin
          tmp <= prod;
        end
        if (s == 2'd2) begin
          w[k] <= area_neg ? -edge_val : edge_val;
          s    <= '0;
          k    <= (k == 2'd2) ? 2'd0 : k + 1'b1;
        end else begin
          s <= s + 1'b1;
        end
      end
      ST_TEST: begin
        ch <= '0;
        s  <= '0;
      end
      ST_MAC: begin
        acc <= (s == 2'd0) ? '0 : acc_sum;
        s   <= s + 1'b1;
      end
      ST_DIV: begin
        if (div_done) begin
          case (ch)
            2'd0:    z           <= div_quot;
            2'd1:    rgb[23:16]  <= div_quot[7:0];
            2'd2:    rgb[15:8]   <= div_quot[7:0];
            default: rgb[7:0]    <= div_quot[7:0];
          endcase
          ch <= ch + 1'b1;
          s  <= '0;
        end
      end
      ST_WRITE: begin
        if (count != COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
      ST_NEXT: begin
        k <= '0;
        s <= '0;
        if (px == hi_x) begin
          px <= lo_x;
          py <= py + coord_t'(1);
        end else begin
          px <= px + coord_t'(1);
        end
      end
      default: ;
    endcase
  end

  `TZR_ASSERT(a_div_start_idle, clk, rst, div_start |-> !div_busy)
  `TZR_ASSERT(a_write_nearer, clk, rst, (state == ST_WRITE) |-> (z < mem_rdepth))
  `TZR_ASSERT_STEP(a_write_after_div, clk, rst, state == ST_DIV && ch == 2'd3 && div_done, state == ST_WRITE)

endmodule

### src/triangle_zbuffer_rasterizer.sv
// Top level of the triangle rasterizer with depth and color stores.
//
//   Channel   Handshake                  Payload
//   item      item_valid / item_stall    item   (item_t)
//   result    result_valid / result_stall result (result_t)
//   config    cfg_we                     cfg_index, cfg_data
//
// After reset the stores are swept, one entry a cycle, over all the
// MAX_WIDTH*MAX_HEIGHT entries while items stall; a clear item sweeps likewise.
// A read returns the stored depth and color of one pixel, or zeros when it falls
// outside the view. A draw finds the triangle area and the clipped bounding box,
// then tests each box pixel against the triangle's edges; the depth of a pixel inside
// is divided out bit-serially, and a nearer pixel gets its color and is written.
// One item is worked at a time; a finished result waits in the output register
// while the next item is taken.
module triangle_zbuffer_rasterizer
  import tzr_pkg::*;
#(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  input  logic         item_valid,
  output logic         item_stall,
  input  item_t        item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_t      result
);

  logic [7:0]         view_width, view_height;
  logic [COLOR_W-1:0] clear_color;
  view_cfg_t          cfg;

  logic               core_idle, res_push, res_free, start;
  result_t            core_res;
  mem_req_t           mem_req;
  logic [DEPTH_W-1:0] mem_rdepth;
  logic [COLOR_W-1:0] mem_rcolor;
  logic               div_start, div_busy, div_done;
  logic [ACC_W-1:0]   div_num;
  logic [EDGE_W-1:0]  div_den;
  logic [QUOT_W-1:0]  div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_width  <= VIEW_RESET;
      view_height <= VIEW_RESET;
      clear_color <= CLEAR_COLOR_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_VIEW_WIDTH:  view_width  <= cfg_data[7:0];
        REG_VIEW_HEIGHT: view_height <= cfg_data[7:0];
        REG_CLEAR_COLOR: clear_color <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (view_width == '0) begin
      cfg.last_x = '0;
    end else if (int'(view_width) > MAX_WIDTH) begin
      cfg.last_x = coord_t'(MAX_WIDTH - 1);
    end else begin
      cfg.last_x = coord_t'(view_width) - coord_t'(1);
    end
    if (view_height == '0) begin
      cfg.last_y = '0;
    end else if (int'(view_height) > MAX_HEIGHT) begin
      cfg.last_y = coord_t'(MAX_HEIGHT - 1);
    end else begin
      cfg.last_y = coord_t'(view_height) - coord_t'(1);
    end
    cfg.clear_color = clear_color;
  end

  assign item_stall = !core_idle;
  assign start      = item_valid && core_idle;
  assign res_free   = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      result <= core_res;
    end
  end

  tzr_core #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .start      (start),
    .item       (item),
    .idle       (core_idle),
    .res_push   (res_push),
    .res_free   (res_free),
    .res        (core_res),
    .mem_req    (mem_req),
    .mem_rdepth (mem_rdepth),
    .mem_rcolor (mem_rcolor),
    .div_start  (div_start),
    .div_num    (div_num),
    .div_den    (div_den),
    .div_busy   (div_busy),
    .div_done   (div_done),
    .div_quot   (div_quot)
  );

  tzr_store #(
    .DEPTH (MAX_WIDTH * MAX_HEIGHT)
  ) u_store (
    .clk    (clk),
    .req    (mem_req),
    .rdepth (mem_rdepth),
    .rcolor (mem_rcolor)
  );

  tzr_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .done  (div_done),
    .quot  (div_quot)
  );

endmodule
